[rtl/core/chm_pkg.sv]
`default_nettype none
package chm_pkg;

    localparam int BUCKET_BITS_DEF = 8;
    localparam int POOL_DEPTH_DEF  = 256;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int KEY_W           = 64;
    localparam int VAL_W           = 64;
    localparam int CNT_W           = 9;
    localparam int BW_W            = 4;
    localparam logic [3:0] BW_RESET = 4'd8;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic hash_step;
        logic clear;
        logic head_rd;
        logic follow;
        logic node_rd;
        logic ovw;
        logic link_new;
        logic fin;
        logic set_found;
        logic set_full;
    } chm_cmd_t;

    // datapath status
    typedef struct packed {
        logic hash_done;
        logic chain_end;
        logic key_hit;
        logic pool_full;
    } chm_sts_t;

    localparam logic [31:0] CRC_TAB [256] = '{
      32'h46d1e192, 32'h66edf9aa, 32'h927fc9e5, 32'ha53baacc, 32'h29b47658, 32'h5a411a01,
      32'h0e66d5bd, 32'h0dd5b1db, 32'hcb38340e, 32'h04d4ebb6, 32'h98bc4f54, 32'h36f20f2c,
      32'h4a3047ed, 32'h1ec1e0eb, 32'h568c0c1f, 32'h6a731432, 32'h81367fc6, 32'he3e25237,
      32'he7f64884, 32'h0fa59f64, 32'h4f3109de, 32'hf02d61f5, 32'h5daec03b, 32'h7f740e83,
      32'h056ff2d8, 32'h2026cc0a, 32'h7ac2112d, 32'h82c55605, 32'hb0911ef2, 32'ha7b88e4c,
      32'h89dca282, 32'h4b254d27, 32'h7694a6d3, 32'hd229eadd, 32'h8e8f3738, 32'h5bee7a55,
      32'h012eb6ab, 32'h08dd28c8, 32'hb5abc274, 32'hbc7931f0, 32'hf2396ed5, 32'he4e43d97,
      32'h943f4b7f, 32'h85d0293d, 32'haed83a88, 32'hc8f932fc, 32'hc5496f20, 32'he9228173,
      32'h9b465b7d, 32'hfda26680, 32'h1ddeab35, 32'h0c4f25cb, 32'h86e32faf, 32'he59fa13a,
      32'he192e2c4, 32'hf147da1a, 32'h67620a8d, 32'h5c9a24c5, 32'hfe6afde2, 32'hacad0250,
      32'hd359730b, 32'hf35203b3, 32'h96a4b44d, 32'hfbcacea6, 32'h41a165ec, 32'hd71e53ac,
      32'h835f39bf, 32'h6b6bde7e, 32'hd07085ba, 32'h79064e07, 32'hee5b20c3, 32'h3b90bd65,
      32'h5827aef4, 32'h4d12d31c, 32'h9143496e, 32'h6c485976, 32'hd9552733, 32'h220f6895,
      32'he69def19, 32'heb89cd70, 32'hc9bb9644, 32'h93ec7e0d, 32'h2ace3842, 32'h2b6158da,
      32'h039e9178, 32'hbb5367d7, 32'h55682285, 32'h4315d891, 32'h19fd8906, 32'h7d8d4448,
      32'hb4168a03, 32'h40b56a53, 32'haa3e69e0, 32'ha25182fe, 32'had34d16c, 32'h720c4171,
      32'h9dc3b961, 32'h321db563, 32'h8b801b9e, 32'hf5971893, 32'h14cc1251, 32'h8f4ae962,
      32'hf65aff1e, 32'h13bd9dee, 32'h5e7c78c7, 32'hddb61731, 32'h73832c15, 32'hefebdd5b,
      32'h1f959aca, 32'he801fb22, 32'ha89826ce, 32'h30b7165d, 32'h458a4077, 32'h24fec52a,
      32'h849b065f, 32'h3c6930cd, 32'ha199a81d, 32'hdb768f30, 32'h2e45c64a, 32'hff2f0d94,
      32'h4ea97917, 32'h6f572acf, 32'h653a195c, 32'h17a88c5a, 32'h27e11fb5, 32'h3f09c4c1,
      32'h2f87e71b, 32'hea1493e4, 32'hd4b3a55e, 32'hbe6090be, 32'haf6cd9d9, 32'hda58ca00,
      32'h612b7034, 32'h31711dad, 32'h6d7db041, 32'h8ca786b7, 32'h09e8bf7a, 32'hc3c4d7ea,
      32'ha3cd77a8, 32'h7700f608, 32'hdf3de559, 32'h71c9353f, 32'h9fd236fb, 32'h1675d43e,
      32'h390d9e9a, 32'h21ba4c6b, 32'hbd1371e8, 32'h90338440, 32'hd5f163d2, 32'hb140fef9,
      32'h52f50b57, 32'h3710cf67, 32'h4c11a79c, 32'hc6d6624e, 32'h3dc7afa9, 32'h34a69969,
      32'h70544a26, 32'hf7d9ec98, 32'h7c027496, 32'h1bfb3ba3, 32'hb3b1dc8f, 32'h9a241039,
      32'hf993f5a4, 32'h15786b99, 32'h26e704f7, 32'h51503c04, 32'h028bb3b8, 32'hede5600c,
      32'h9cb22b29, 32'hb6ff339b, 32'h7e771c43, 32'hc71c05f1, 32'h604ca924, 32'h695eed60,
      32'h688ed0bc, 32'h3e0b232f, 32'hf8a39c11, 32'hbae6e67c, 32'hb8cf75e1, 32'h970321a7,
      32'h5328922b, 32'hdef3df2e, 32'h8d0443b0, 32'h2885e3ae, 32'h6435eed1, 32'hcc375e81,
      32'ha98495f6, 32'he0bff114, 32'hb2da3e4f, 32'hc01b5adf, 32'h507e0721, 32'h6267a36a,
      32'h181a6df8, 32'h7baff0c0, 32'hfa6d6c13, 32'h427250b2, 32'he2f742d6, 32'hcd5cc723,
      32'h2d218be7, 32'hb91fbbb1, 32'h9eb946d0, 32'h1c180810, 32'hfc81d602, 32'h0b9c3f52,
      32'hc2ea456f, 32'h1165b2c9, 32'habf4ad75, 32'h0a56fc8c, 32'h12e0f818, 32'hcadbcba1,
      32'h2586be56, 32'h952c9b46, 32'h07c6a43c, 32'h78967df3, 32'h477b2e49, 32'h2c5d7b6d,
      32'h8a637272, 32'h59acbcb4, 32'h74a0e447, 32'hc1f8800f, 32'h35c015dc, 32'h230794c2,
      32'h4405f328, 32'hec2adba5, 32'hd832b845, 32'h6e4ed287, 32'h48e9f7a2, 32'ha44be89f,
      32'h38cbb725, 32'hbf6ef4e6, 32'hdc0e83fa, 32'h54238d12, 32'hf4f0c1e3, 32'ha60857fd,
      32'hc43c64b9, 32'h00c851ef, 32'h33d75f36, 32'h5fd39866, 32'hd1efa08a, 32'ha0640089,
      32'h877a978b, 32'h99175d86, 32'h57dfacbb, 32'hceb02de9, 32'hcf4d5c09, 32'h3a8813d4,
      32'hb7448816, 32'h63fa5568, 32'h06be014b, 32'hd642fa7b, 32'h10aa7c90, 32'h8082c88e,
      32'h1afcba79, 32'h7519549d, 32'h490a87ff, 32'h8820c3a0
    };

endpackage
`default_nettype wire

[rtl/core/chm_ctrl.sv]
`default_nettype none
module chm_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       req_type,
    input  wire chm_pkg::chm_sts_t sts,
    output logic                  busy,
    output logic                  done,
    output chm_pkg::chm_cmd_t     cmd
);
    import chm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_NODE = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] req_reg, req_next;
    logic       done_reg, done_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // the done cycle still reports busy, so no start is taken then
                if (start && !done_reg)
                begin
                    cmd.load = 1'b1;
                    req_next = req_type;
                    if (req_type == REQ_INSERT || req_type == REQ_LOOKUP)
                        state_next = S_HASH;
                    else
                    begin
                        if (req_type == REQ_CLEAR)
                            cmd.clear = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_NODE;
            end
            S_NODE:
            begin
                if (sts.chain_end)
                begin
                    if (req_reg == REQ_INSERT)
                    begin
                        if (sts.pool_full)
                            cmd.set_full = 1'b1;
                        else
                            cmd.link_new = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.key_hit)
                begin
                    cmd.set_found = 1'b1;
                    cmd.ovw       = (req_reg == REQ_INSERT);
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.follow = 1'b1;
                    state_next = S_NODE;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= REQ_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> done_reg)
        else $error("done missing after finish");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> busy)
        else $error("busy low while working");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held two cycles");
endmodule
`default_nettype wire

[rtl/core/chm_dp.sv]
`default_nettype none
module chm_dp
#(
    parameter int BUCKET_BITS = chm_pkg::BUCKET_BITS_DEF,
    parameter int POOL_DEPTH  = chm_pkg::POOL_DEPTH_DEF,
    parameter int KEY_BYTES   = chm_pkg::KEY_BYTES_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire chm_pkg::chm_cmd_t        cmd,
    input  wire logic [chm_pkg::BW_W-1:0] bucket_width,
    input  wire logic [chm_pkg::KEY_W-1:0] key,
    input  wire logic [chm_pkg::VAL_W-1:0] value,
    output chm_pkg::chm_sts_t             sts,
    output logic                          found,
    output logic [chm_pkg::VAL_W-1:0]     found_value,
    output logic                          status,
    output logic [chm_pkg::CNT_W-1:0]     stored_entries
);
    import chm_pkg::*;

    localparam int NB  = 1 << BUCKET_BITS;
    localparam int NW  = $clog2(POOL_DEPTH);
    localparam int TW  = $clog2(POOL_DEPTH + 1);
    localparam int BYW = $clog2(KEY_BYTES + 1);

    // node pool and bucket heads
    logic [KEY_W-1:0] key_mem [POOL_DEPTH];
    logic [VAL_W-1:0] val_mem [POOL_DEPTH];
    logic [NW-1:0]    link_mem [POOL_DEPTH];
    logic             lv_mem [POOL_DEPTH];
    logic [NW-1:0]    head_mem [NB];
    logic [NB-1:0]    bvalid_reg;

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [31:0]      hash_reg;
    logic [BYW-1:0]   byte_reg;
    logic [BUCKET_BITS-1:0] bkt_reg;
    logic [TW-1:0]    total_reg;
    logic [TW-1:0]    steps_reg;
    logic [NW-1:0]    node_reg;
    logic             nv_reg;
    logic [KEY_W-1:0] nkey_reg;
    logic [VAL_W-1:0] nval_reg;
    logic [NW-1:0]    nlink_reg;
    logic             nlv_reg;
    logic [NW-1:0]    head_rd_reg;
    logic             head_sel_reg;
    logic             found_reg;
    logic             full_reg;
    logic [VAL_W-1:0] fval_reg;
    logic [KEY_W-1:0] key_orig_reg;

    logic [31:0]      hash_next;
    logic [7:0]       kbyte;
    logic [3:0]       wclamp;
    logic [BUCKET_BITS-1:0] bkt_next;
    logic [NW-1:0]    cur_node;
    logic [KEY_W-1:0] key_reg_cmp;

    // one hash byte per cycle
    assign kbyte     = key_reg[7:0];
    assign hash_next = (hash_reg >> 8) ^ CRC_TAB[hash_reg[7:0] ^ kbyte];

    always_comb
    begin
        wclamp = bucket_width;
        if (wclamp == 4'd0)
            wclamp = 4'd1;
        if (32'(wclamp) > BUCKET_BITS)
            wclamp = 4'(BUCKET_BITS);
        bkt_next = hash_reg[BUCKET_BITS-1:0]
            & BUCKET_BITS'((32'd1 << wclamp) - 32'd1);
    end

    // current chain position: head read or followed link
    assign cur_node = head_sel_reg ? head_rd_reg : node_reg;

    assign key_reg_cmp = key_orig_reg;

    assign sts.hash_done = (byte_reg == BYW'(KEY_BYTES - 1));
    assign sts.chain_end = !nv_reg || (steps_reg >= total_reg);
    assign sts.key_hit   = (nkey_reg == key_reg_cmp);
    assign sts.pool_full = (total_reg >= TW'(POOL_DEPTH));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= '0;
            total_reg  <= '0;
            found_reg  <= 1'b0;
            full_reg   <= 1'b0;
            nv_reg     <= 1'b0;
            byte_reg   <= '0;
            steps_reg  <= '0;
            head_sel_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                full_reg  <= 1'b0;
                byte_reg  <= '0;
            end
            if (cmd.clear)
            begin
                bvalid_reg <= '0;
                total_reg  <= '0;
            end
            if (cmd.hash_step)
                byte_reg <= byte_reg + BYW'(1);
            if (cmd.head_rd)
            begin
                nv_reg       <= bvalid_reg[bkt_next];
                steps_reg    <= '0;
                head_sel_reg <= 1'b1;
            end
            if (cmd.node_rd)
                head_sel_reg <= 1'b0;
            if (cmd.follow)
            begin
                nv_reg    <= nlv_reg;
                steps_reg <= steps_reg + TW'(1);
            end
            if (cmd.link_new)
            begin
                bvalid_reg[bkt_reg] <= 1'b1;
                total_reg <= total_reg + TW'(1);
            end
            if (cmd.set_found)
                found_reg <= 1'b1;
            if (cmd.set_full)
                full_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= key;
            key_orig_reg <= key;
            val_reg      <= value;
            hash_reg     <= 32'(KEY_BYTES);
            fval_reg     <= '0;
        end
        if (cmd.hash_step)
        begin
            hash_reg <= hash_next;
            key_reg  <= key_reg >> 8;
        end
        if (cmd.head_rd)
            bkt_reg <= bkt_next;
        if (cmd.follow)
            node_reg <= nlink_reg;
        if (cmd.node_rd)
            node_reg <= cur_node;
        if (cmd.set_found && !cmd.ovw)
            fval_reg <= nval_reg;
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
            head_rd_reg <= head_mem[bkt_next];
        if (cmd.link_new)
            head_mem[bkt_reg] <= total_reg[NW-1:0];
    end

    // node memories, one access per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.node_rd)
        begin
            nkey_reg  <= key_mem[cur_node];
            nval_reg  <= val_mem[cur_node];
            nlink_reg <= link_mem[cur_node];
            nlv_reg   <= lv_mem[cur_node];
        end
        if (cmd.link_new)
        begin
            key_mem[total_reg[NW-1:0]]  <= key_orig_reg;
            val_mem[total_reg[NW-1:0]]  <= val_reg;
            link_mem[total_reg[NW-1:0]] <= head_rd_reg;
            lv_mem[total_reg[NW-1:0]]   <= bvalid_reg[bkt_reg];
        end
        if (cmd.ovw)
            val_mem[node_reg] <= val_reg;
    end

    assign found          = found_reg;
    assign found_value    = fval_reg;
    assign status         = full_reg;
    assign stored_entries = CNT_W'(total_reg);

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(POOL_DEPTH))
        else $error("entry count past pool");
    a_link_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_new |=> total_reg == $past(total_reg) + TW'(1))
        else $error("count not bumped on link");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (total_reg == '0) && (bvalid_reg == '0))
        else $error("clear incomplete");
    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(found_reg && full_reg))
        else $error("hit and full together");
endmodule
`default_nettype wire

[rtl/core/chained_hash_map_engine.sv]
// clear and reserved codes: start, then the finish state, then done
// insert and lookup: start, hash over the KEY_BYTES key bytes, a head read, a
// node read and key compare per chain node visited, then finish and done
// one transaction at a time: start is taken again the cycle after done
// reset empties all buckets, zeroes the count and sets bucket_width to 8
`default_nettype none
module chained_hash_map_engine
#(
    parameter int BUCKET_BITS = chm_pkg::BUCKET_BITS_DEF,
    parameter int POOL_DEPTH  = chm_pkg::POOL_DEPTH_DEF,
    parameter int KEY_BYTES   = chm_pkg::KEY_BYTES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                req_type,
    input  wire logic [chm_pkg::KEY_W-1:0] key,
    input  wire logic [chm_pkg::VAL_W-1:0] value,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [chm_pkg::BW_W-1:0]  cfg_data,
    output logic                           done,
    output logic                           found,
    output logic [chm_pkg::VAL_W-1:0]      found_value,
    output logic                           status,
    output logic [chm_pkg::CNT_W-1:0]      stored_entries
);
    import chm_pkg::*;

    logic [BW_W-1:0] bw_reg;
    chm_cmd_t cmd;
    chm_sts_t sts;

    // bucket width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bw_reg <= BW_RESET;
        else if (cfg_valid && cfg_ready)
            bw_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    chm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    chm_dp #(
        .BUCKET_BITS (BUCKET_BITS),
        .POOL_DEPTH  (POOL_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .bucket_width   (bw_reg),
        .key            (key),
        .value          (value),
        .sts            (sts),
        .found          (found),
        .found_value    (found_value),
        .status         (status),
        .stored_entries (stored_entries)
    );
endmodule
`default_nettype wire

[dv/tb_chained_hash_map_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_chained_hash_map_engine;
    import chm_pkg::*;

    localparam int NBUCKETS  = 256;
    localparam int NPOOL     = 256;
    localparam int IDLE_LIM  = 20000;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]       req;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
    } map_req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] hit_val;
        logic             full;
        logic [CNT_W-1:0] count;
    } map_resp_t;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    logic [1:0] req_type = REQ_CLEAR;
    logic [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0] value = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [BW_W-1:0] cfg_data = '0;
    logic done;
    logic found;
    logic [VAL_W-1:0] found_value;
    logic status;
    logic [CNT_W-1:0] stored_entries;

    chained_hash_map_engine DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .key(key), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .found(found), .found_value(found_value),
        .status(status), .stored_entries(stored_entries)
    );

    // shadow map state
    logic [3:0]       mdl_width;
    logic             mdl_head_ok [NBUCKETS];
    logic [8:0]       mdl_head    [NBUCKETS];
    logic [KEY_W-1:0] mdl_key     [NPOOL];
    logic [VAL_W-1:0] mdl_val     [NPOOL];
    logic             mdl_link_ok [NPOOL];
    logic [8:0]       mdl_link    [NPOOL];
    int unsigned      mdl_total;

    map_req_t  pending_reqs [$];
    map_resp_t awaited_resps [$];
    logic [KEY_W-1:0] used_keys [$];

    int  errors;
    int  idle_cycles;
    int  send_idle_pct;
    bit  hold_send;
    bit  cfg_pend;
    bit  took_req;
    bit  cfg_took;
    logic [3:0] cfg_next;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] key_crc(logic [KEY_W-1:0] k);
        logic [31:0] h;
        logic [7:0]  b;
        h = 32'd8;
        for (int i = 0; i < 8; i++)
        begin
            b = k[8*i +: 8];
            h = (h >> 8) ^ CRC_TAB[h[7:0] ^ b];
        end
        return h;
    endfunction

    function automatic int bucket_pick(logic [KEY_W-1:0] k);
        int w;
        w = mdl_width;
        if (w < 1) w = 1;
        if (w > 8) w = 8;
        return int'(key_crc(k) & ((32'd1 << w) - 1));
    endfunction

    function automatic int chain_search(int b, logic [KEY_W-1:0] k);
        logic ok;
        int   n;
        int   steps;
        ok = mdl_head_ok[b];
        n = mdl_head[b];
        steps = 0;
        while (ok && n < NPOOL && steps < mdl_total)
        begin
            if (mdl_key[n] == k) return n;
            ok = mdl_link_ok[n];
            n = mdl_link[n];
            steps++;
        end
        return -1;
    endfunction

    // work out the response of one accepted transaction
    function automatic map_resp_t map_apply(map_req_t r);
        map_resp_t o;
        int b;
        int n;
        o = '0;
        if (r.req == REQ_CLEAR)
        begin
            for (int i = 0; i < NBUCKETS; i++) mdl_head_ok[i] = 1'b0;
            mdl_total = 0;
        end
        else if (r.req == REQ_INSERT)
        begin
            b = bucket_pick(r.k);
            n = chain_search(b, r.k);
            if (n >= 0)
            begin
                mdl_val[n] = r.v;
                o.hit = 1'b1;
            end
            else if (mdl_total >= NPOOL)
                o.full = 1'b1;
            else
            begin
                n = mdl_total;
                mdl_key[n] = r.k;
                mdl_val[n] = r.v;
                mdl_link_ok[n] = mdl_head_ok[b];
                mdl_link[n] = mdl_head[b];
                mdl_head[b] = n[8:0];
                mdl_head_ok[b] = 1'b1;
                mdl_total++;
            end
        end
        else if (r.req == REQ_LOOKUP)
        begin
            b = bucket_pick(r.k);
            n = chain_search(b, r.k);
            if (n >= 0)
            begin
                o.hit = 1'b1;
                o.hit_val = mdl_val[n];
            end
        end
        o.count = mdl_total[8:0];
        return o;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // key from a small reused set most of the time so chains fill and hit
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if (used_keys.size() > 0 && $urandom_range(0, 99) < 55)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0: k = 64'(1) << $urandom_range(0, 63);
            1: k = ~(64'(1) << $urandom_range(0, 63));
            default: k = rnd64();
        endcase
        used_keys.push_back(k);
        if (used_keys.size() > 400) void'(used_keys.pop_front());
        return k;
    endfunction

    function automatic map_req_t rand_req();
        map_req_t r;
        int p;
        p = $urandom_range(0, 99);
        if (p < 1) r.req = REQ_CLEAR;
        else if (p < 3) r.req = REQ_RSVD;
        else if (p < 55) r.req = REQ_INSERT;
        else r.req = REQ_LOOKUP;
        r.k = pick_key();
        r.v = rnd64();
        return r;
    endfunction

    task automatic push_req(logic [1:0] t, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        map_req_t r;
        r.req = t;
        r.k = k;
        r.v = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || awaited_resps.size() > 0 || start || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register write, only with the engine idle
    task automatic write_width(logic [3:0] w);
        wait_drained();
        cfg_next = w;
        cfg_pend = 1'b1;
        while (cfg_pend) @(posedge clk);
    endtask

    task automatic random_phase(int n, int pct);
        send_idle_pct = pct;
        for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
        wait_drained();
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a start refused while busy stays up unchanged
            if (!start || took_req)
            begin
                if (!hold_send && pending_reqs.size() > 0 && !cfg_valid &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    start    <= 1'b1;
                    req_type <= pending_reqs[0].req;
                    key      <= pending_reqs[0].k;
                    value    <= pending_reqs[0].v;
                end
                else
                    start <= 1'b0;
            end
            if (cfg_valid && cfg_took)
                cfg_valid <= 1'b0;
            else if (cfg_pend && !cfg_valid && !start && !busy)
            begin
                cfg_valid <= 1'b1;
                cfg_data  <= cfg_next;
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        map_resp_t e;
        bit moved;
        moved = 1'b0;
        took_req = rst_n && start && !busy;
        cfg_took = rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (took_req)
            begin
                awaited_resps.push_back(map_apply(pending_reqs.pop_front()));
                moved = 1'b1;
            end
            if (cfg_took)
            begin
                mdl_width = cfg_data;
                cfg_pend = 1'b0;
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (awaited_resps.size() == 0)
                begin
                    $error("unexpected response transaction");
                    errors++;
                end
                else
                begin
                    e = awaited_resps.pop_front();
                    if (found !== e.hit)
                    begin
                        $error("found: expected %0h got %0h", e.hit, found);
                        errors++;
                    end
                    if (found_value !== e.hit_val)
                    begin
                        $error("found_value: expected %0h got %0h", e.hit_val, found_value);
                        errors++;
                    end
                    if (status !== e.full)
                    begin
                        $error("status: expected %0h got %0h", e.full, status);
                        errors++;
                    end
                    if (stored_entries !== e.count)
                    begin
                        $error("stored_entries: expected %0h got %0h", e.count,
                               stored_entries);
                        errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIM)
            begin
                $display("tb_chained_hash_map_engine: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        hold_send = 1'b0;
        cfg_pend = 1'b0;
        took_req = 1'b0;
        cfg_took = 1'b0;
        cfg_next = '0;
        mdl_width = BW_RESET;
        mdl_total = 0;
        for (int i = 0; i < NBUCKETS; i++)
        begin
            mdl_head_ok[i] = 1'b0;
            mdl_head[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every request code, overwrite, width clamps
        push_req(REQ_LOOKUP, '0, '0);
        push_req(REQ_INSERT, '0, '1);
        push_req(REQ_INSERT, '1, '0);
        push_req(REQ_LOOKUP, '0, 64'h5);
        push_req(REQ_LOOKUP, '1, '0);
        push_req(REQ_INSERT, '1, 64'h0123456789abcdef);
        push_req(REQ_LOOKUP, '1, '0);
        push_req(REQ_RSVD, '1, '1);
        push_req(REQ_LOOKUP, 64'h8000000000000000, '0);
        push_req(REQ_CLEAR, '1, '1);
        push_req(REQ_LOOKUP, '1, '0);
        wait_drained();
        write_width(4'd0);
        for (int i = 0; i < 6; i++) push_req(REQ_INSERT, 64'(i), rnd64());
        for (int i = 0; i < 7; i++) push_req(REQ_LOOKUP, 64'(i), '0);
        wait_drained();
        // width changed with entries present, no rehash
        write_width(4'd15);
        for (int i = 0; i < 6; i++) push_req(REQ_LOOKUP, 64'(i), '0);
        wait_drained();
        // fill the pool past its depth with width 1, long chains
        write_width(4'd1);
        push_req(REQ_CLEAR, '0, '0);
        for (int i = 0; i < NPOOL + 4; i++) push_req(REQ_INSERT, rnd64(), rnd64());
        push_req(REQ_INSERT, 64'(0), 64'h77);
        push_req(REQ_LOOKUP, 64'(0), '0);
        random_phase(60, 0);
        push_req(REQ_CLEAR, '0, '0);

        // random phases over several widths and idling levels
        write_width(4'd8);
        random_phase(360, 0);
        write_width(4'd3);
        random_phase(360, 73);
        hold_send = 1'b1;
        wait_drained();
        hold_send = 1'b0;
        write_width(4'($urandom_range(1, 8)));
        random_phase(360, 17);
        write_width(4'd9);
        random_phase(360, 0);

        wait_drained();
        if (errors == 0)
            $display("tb_chained_hash_map_engine: done, clean");
        else
            $display("tb_chained_hash_map_engine: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/chm_pkg.sv
rtl/core/chm_ctrl.sv
rtl/core/chm_dp.sv
rtl/core/chained_hash_map_engine.sv
dv/tb_chained_hash_map_engine.sv
